[hw/rtl/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte update for the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam int RAW_W  = 16;
	localparam int TEMP_W = 15;
	localparam int HUM_W  = 14;
	localparam int TPROD_W = 31;
	localparam int HPROD_W = 30;

	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;
	// 4500 * 65535: products below this give a negative temperature
	localparam logic [TPROD_W-1:0] TEMP_ZERO_PROD = 31'd294907500;

	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	typedef struct packed {
		logic             ok;
		logic [RAW_W-1:0] temp_raw;
		logic [RAW_W-1:0] hum_raw;
	} frame_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/htfd_frame.sv]
// ----------------------------------------------------------------------------
// htfd_frame
// Byte position tracking, CRC checks and word assembly; holds one finished
// frame in the s1 register until the conversion stage takes it.
// ----------------------------------------------------------------------------
module htfd_frame import htfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       frm_valid,
	input  logic       frm_ready,
	output frame_t     frm
);

	pos_t             pos_q, pos_cur, pos_nxt;
	logic [7:0]       crc_q, crc_cur, crc_nxt;
	logic             fwok_q, fwok_nxt;
	logic [RAW_W-1:0] temp_q, temp_nxt;
	logic [RAW_W-1:0] hum_q, hum_nxt;
	logic             valid_s1;
	frame_t           frame_s1;
	logic             accept;
	logic             done;
	logic             restart;

	assign in_ready  = !valid_s1 || frm_ready;
	assign accept    = in_valid && in_ready;
	assign frm_valid = valid_s1;
	assign frm       = frame_s1;

	assign restart = frame_start || (pos_q > POS_H_CRC);
	assign pos_cur = restart ? POS_T_HI : pos_q;
	assign crc_cur = restart ? CRC_INIT : crc_q;

	// next state
	always_comb begin
		unique case (pos_cur)
			POS_T_HI:  pos_nxt = POS_T_LO;
			POS_T_LO:  pos_nxt = POS_T_CRC;
			POS_T_CRC: pos_nxt = POS_H_HI;
			POS_H_HI:  pos_nxt = POS_H_LO;
			POS_H_LO:  pos_nxt = POS_H_CRC;
			default:   pos_nxt = POS_T_HI;
		endcase
	end

	// datapath
	always_comb begin
		crc_nxt  = crc_cur;
		fwok_nxt = fwok_q;
		temp_nxt = temp_q;
		hum_nxt  = hum_q;
		done     = 1'b0;
		unique case (pos_cur)
			POS_T_HI: begin
				crc_nxt  = crc8_feed(CRC_INIT, rx_byte);
				temp_nxt = {rx_byte, temp_q[7:0]};
			end
			POS_T_LO: begin
				crc_nxt  = crc8_feed(crc_cur, rx_byte);
				temp_nxt = {temp_q[15:8], rx_byte};
			end
			POS_T_CRC: begin
				fwok_nxt = (crc_cur == rx_byte);
				crc_nxt  = CRC_INIT;
			end
			POS_H_HI: begin
				crc_nxt = crc8_feed(crc_cur, rx_byte);
				hum_nxt = {rx_byte, hum_q[7:0]};
			end
			POS_H_LO: begin
				crc_nxt = crc8_feed(crc_cur, rx_byte);
				hum_nxt = {hum_q[15:8], rx_byte};
			end
			default: begin
				crc_nxt = CRC_INIT;
				done    = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_T_HI;
			crc_q    <= CRC_INIT;
			fwok_q   <= 1'b0;
			temp_q   <= '0;
			hum_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q  <= pos_nxt;
				crc_q  <= crc_nxt;
				fwok_q <= fwok_nxt;
				temp_q <= temp_nxt;
				hum_q  <= hum_nxt;
			end
			if (in_ready) begin
				valid_s1 <= accept && done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && done) begin
			frame_s1.ok       <= fwok_q && (crc_cur == rx_byte);
			frame_s1.temp_raw <= temp_q;
			frame_s1.hum_raw  <= hum_q;
		end
	end

endmodule

[hw/rtl/htfd_convert.sv]
// ----------------------------------------------------------------------------
// htfd_convert
// Scales the raw words (s2: constant multiplies) and divides by full scale
// with one correction step into the output register.
// ----------------------------------------------------------------------------
module htfd_convert import htfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frm_valid,
	output logic        frm_ready,
	input  frame_t      frm,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tuser
);

	logic               valid_s2;
	logic               ok_s2;
	logic [TPROD_W-1:0] tprod_s2;
	logic [HPROD_W-1:0] hprod_s2;
	logic               valid_q;
	logic               ok_q;
	logic [TEMP_W-1:0]  temp_q;
	logic [HUM_W-1:0]   hum_q;
	logic               out_adv;
	logic               s2_adv;

	logic [16:0]        t_rem0, h_rem0;
	logic               t_ge, h_ge, t_rnz, t_neg;
	logic [TEMP_W-1:0]  t_quo;
	logic [HUM_W-1:0]   h_quo;
	logic [15:0]        t_signed;

	assign out_adv   = !valid_q || m_tready;
	assign s2_adv    = !valid_s2 || out_adv;
	assign frm_ready = s2_adv;

	// x / 65535: x = q0*65536 + l = q0*65535 + (q0 + l), remainder below 2*65535
	always_comb begin
		t_rem0   = {2'b0, tprod_s2[30:16]} + {1'b0, tprod_s2[15:0]};
		t_ge     = (t_rem0 >= FULL_SCALE);
		t_rnz    = t_ge ? (t_rem0 != FULL_SCALE) : (t_rem0 != 17'd0);
		t_neg    = (tprod_s2 < TEMP_ZERO_PROD);
		t_quo    = tprod_s2[30:16] + {14'd0, t_ge} + {14'd0, t_neg && t_rnz};
		t_signed = {1'b0, t_quo} - TEMP_OFFSET;
		h_rem0   = {3'b0, hprod_s2[29:16]} + {1'b0, hprod_s2[15:0]};
		h_ge     = (h_rem0 >= FULL_SCALE);
		h_quo    = hprod_s2[29:16] + {13'd0, h_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s2_adv) begin
				valid_s2 <= frm_valid;
			end
			if (out_adv) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && frm_valid) begin
			ok_s2    <= frm.ok;
			tprod_s2 <= {16'd0, TEMP_SCALE} * {15'd0, frm.temp_raw};
			hprod_s2 <= {16'd0, HUM_SCALE} * {14'd0, frm.hum_raw};
		end
		if (out_adv && valid_s2) begin
			ok_q   <= ok_s2;
			temp_q <= ok_s2 ? t_signed[TEMP_W-1:0] : '0;
			hum_q  <= ok_s2 ? h_quo : '0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {3'b000, hum_q, temp_q};

endmodule

[hw/rtl/humidity_temp_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes six-byte temperature/humidity frames with CRC-8 checks.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, sustained unless the result side stalls; a byte
// with tuser high starts a new frame. Frame order: temperature high, low, CRC,
// humidity high, low, CRC (CRC-8, poly 0x31, init 0xFF). The sixth byte
// yields one result beat: the frame register loads on the accepting edge,
// then the constant-multiply stage, then the divide-by-65535 correction into
// the output register. tuser on the result is the valid flag; on a CRC
// mismatch both readings are zero.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top import htfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [14:0] temp_centideg, [28:15] hum_centipct
	output logic        m_tuser   // reading_valid
);

	logic   frm_valid;
	logic   frm_ready;
	frame_t frm;

	htfd_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.frm_valid   (frm_valid),
		.frm_ready   (frm_ready),
		.frm         (frm)
	);

	htfd_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

[hw/rtl/htfd_checker.sv]
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks on the decoder result stream.
// ----------------------------------------------------------------------------
module htfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("invalid reading carries nonzero data");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[28:15] <= 14'd10000 && m_tdata[31:29] == 3'b000)
		else $error("humidity out of range");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[14:0]) >= -15'sd4500
			&& $signed(m_tdata[14:0]) <= 15'sd13000)
		else $error("temperature out of range");

endmodule

bind humidity_temp_frame_decoder_top htfd_checker u_htfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
